// ===== rtl/hdrscan_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// hdrscan_pkg
// Types, constants and the name character map for the header line scanner.
// ----------------------------------------------------------------------------
package hdrscan_pkg;

  localparam int NAME_BUF_LEN = 32;
  localparam int MAX_LINE_LEN = 4096;
  localparam int NAME_IDX_W   = $clog2(NAME_BUF_LEN);
  localparam int LINE_POS_W   = $clog2(MAX_LINE_LEN);
  localparam int HASH_W       = 64;

  localparam logic [NAME_IDX_W-1:0] NAME_IDX_LAST = NAME_IDX_W'(NAME_BUF_LEN - 1);
  localparam logic [LINE_POS_W-1:0] LINE_POS_LAST = LINE_POS_W'(MAX_LINE_LEN - 1);

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_LF    = 8'h0a;
  localparam logic [7:0] CH_CR    = 8'h0d;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_COLON = 8'h3a;
  localparam logic [7:0] CH_USCORE = 8'h5f;
  localparam logic [7:0] CH_DEL   = 8'h7f;

  typedef enum logic [2:0] {
    ST_START      = 3'd0,
    ST_NAME       = 3'd1,
    ST_SP_BEFORE  = 3'd2,
    ST_VALUE      = 3'd3,
    ST_SP_AFTER   = 3'd4,
    ST_ALMOST     = 3'd5,
    ST_HDR_ALMOST = 3'd6
  } scan_state_t;

  typedef enum logic [1:0] {
    EV_CONT = 2'd0,
    EV_LINE = 2'd1,
    EV_HDR  = 2'd2,
    EV_BAD  = 2'd3
  } scan_event_t;

  // Lowercase map for token characters; zero means "not a plain name char".
  function automatic logic [7:0] lower_map(input logic [7:0] c);
    logic [7:0] r;
    r = 8'h00;
    if (c == 8'h2d) r = c;
    else if (c >= 8'h30 && c <= 8'h39) r = c;
    else if (c >= 8'h61 && c <= 8'h7a) r = c;
    else if (c >= 8'h41 && c <= 8'h5a) r = c + 8'h20;
    return r;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/http_header_line_scanner_top.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// http_header_line_scanner_top
// Per-byte HTTP header line scanner with lowercased name hash and positions.
// ----------------------------------------------------------------------------
// One header byte is taken per transaction and one result is returned per
// byte. A byte sits in an input register, is decoded against the scanner
// state in a single pass, and the result lands in an output register when
// the input register advances, so the block sustains one byte every cycle
// while out_stall is low; the hash update is a 64-bit shift-subtract-add.
// The underscores_allowed bit is written through wr_en / wr_data and should
// only change while no byte is in flight. Line positions saturate at the
// last offset of a maximum-length line.
module http_header_line_scanner_top
  import hdrscan_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,

  input  wire logic        wr_en,
  input  wire logic        wr_data,

  input  wire logic        in_valid,
  output      logic        in_stall,
  input  wire logic [7:0]  data_byte,

  output      logic        out_valid,
  input  wire logic        out_stall,
  output      logic [1:0]  event_res,
  output      logic        name_char_valid,
  output      logic [7:0]  name_char,
  output      logic [4:0]  name_index,
  output      logic        name_invalid,
  output      logic [63:0] name_hash,
  output      logic [11:0] name_end_pos,
  output      logic [11:0] value_start_pos,
  output      logic [11:0] value_end_pos
);

  logic                  underscores_allowed;

  logic                  s1_valid;
  logic [7:0]            s1_byte;
  logic                  adv;

  scan_state_t           scan_state, scan_state_next;
  logic [HASH_W-1:0]     hash_acc, hash_acc_next;
  logic [NAME_IDX_W-1:0] char_index, char_index_next;
  logic                  bad_name_flag, bad_name_flag_next;
  logic [LINE_POS_W-1:0] line_offset, line_offset_next;
  logic [LINE_POS_W-1:0] name_end_reg, name_end_reg_next;
  logic [LINE_POS_W-1:0] value_start_reg, value_start_reg_next;
  logic [LINE_POS_W-1:0] value_end_reg, value_end_reg_next;

  scan_event_t           ev;
  scan_state_t           st_dec;
  logic                  store;
  logic                  new_name;
  logic [7:0]            sch;
  logic [7:0]            lc;
  logic [LINE_POS_W-1:0] p;
  logic [LINE_POS_W:0]   p_inc;
  logic [HASH_W-1:0]     hash_base;
  logic [NAME_IDX_W-1:0] idx_base;

  // Input register moves on whenever the output register is free or draining.
  assign adv      = s1_valid && (!out_valid || !out_stall);
  assign in_stall = s1_valid && !adv;

  assign p     = (scan_state == ST_START) ? '0 : line_offset;
  assign p_inc = {1'b0, p} + 1'b1;

  // Decode of one byte: event, stored name char, hash and position updates.
  always_comb begin
    ev                   = EV_CONT;
    st_dec               = scan_state;
    store                = 1'b0;
    new_name             = 1'b0;
    sch                  = 8'h00;
    lc                   = lower_map(s1_byte);
    bad_name_flag_next   = bad_name_flag;
    name_end_reg_next    = name_end_reg;
    value_start_reg_next = value_start_reg;
    value_end_reg_next   = value_end_reg;
    case (scan_state)
      ST_START: begin
        bad_name_flag_next = 1'b0;
        if (s1_byte == CH_CR) begin
          value_end_reg_next = p;
          st_dec             = ST_HDR_ALMOST;
        end else if (s1_byte == CH_LF) begin
          value_end_reg_next = p;
          ev                 = EV_HDR;
        end else begin
          new_name = 1'b1;
          st_dec   = ST_NAME;
          if (lc != 8'h00) begin
            sch   = lc;
            store = 1'b1;
          end else if (s1_byte == CH_USCORE) begin
            if (underscores_allowed) begin
              sch   = s1_byte;
              store = 1'b1;
            end else begin
              bad_name_flag_next = 1'b1;
            end
          end else if (s1_byte <= CH_SPACE || s1_byte == CH_DEL ||
                       s1_byte == CH_COLON) begin
            value_end_reg_next = p;
            ev                 = EV_BAD;
          end else begin
            bad_name_flag_next = 1'b1;
          end
        end
      end
      ST_NAME: begin
        if (lc != 8'h00) begin
          sch   = lc;
          store = 1'b1;
        end else if (s1_byte == CH_USCORE) begin
          if (underscores_allowed) begin
            sch   = s1_byte;
            store = 1'b1;
          end else begin
            bad_name_flag_next = 1'b1;
          end
        end else if (s1_byte == CH_COLON) begin
          name_end_reg_next = p;
          st_dec            = ST_SP_BEFORE;
        end else if (s1_byte == CH_CR || s1_byte == CH_LF) begin
          name_end_reg_next    = p;
          value_start_reg_next = p;
          value_end_reg_next   = p;
          if (s1_byte == CH_CR) st_dec = ST_ALMOST;
          else ev = EV_LINE;
        end else if (s1_byte <= CH_SPACE || s1_byte == CH_DEL) begin
          value_end_reg_next = p;
          ev                 = EV_BAD;
        end else begin
          bad_name_flag_next = 1'b1;
        end
      end
      ST_SP_BEFORE: begin
        if (s1_byte == CH_SPACE) begin
          st_dec = ST_SP_BEFORE;
        end else if (s1_byte == CH_CR || s1_byte == CH_LF) begin
          value_start_reg_next = p;
          value_end_reg_next   = p;
          if (s1_byte == CH_CR) st_dec = ST_ALMOST;
          else ev = EV_LINE;
        end else if (s1_byte == CH_NUL) begin
          value_end_reg_next = p;
          ev                 = EV_BAD;
        end else begin
          value_start_reg_next = p;
          st_dec               = ST_VALUE;
        end
      end
      ST_VALUE: begin
        if (s1_byte == CH_SPACE) begin
          value_end_reg_next = p;
          st_dec             = ST_SP_AFTER;
        end else if (s1_byte == CH_CR) begin
          value_end_reg_next = p;
          st_dec             = ST_ALMOST;
        end else if (s1_byte == CH_LF) begin
          value_end_reg_next = p;
          ev                 = EV_LINE;
        end else if (s1_byte == CH_NUL) begin
          value_end_reg_next = p;
          ev                 = EV_BAD;
        end
      end
      ST_SP_AFTER: begin
        if (s1_byte == CH_SPACE) begin
          st_dec = ST_SP_AFTER;
        end else if (s1_byte == CH_CR) begin
          st_dec = ST_ALMOST;
        end else if (s1_byte == CH_LF) begin
          ev = EV_LINE;
        end else if (s1_byte == CH_NUL) begin
          value_end_reg_next = p;
          ev                 = EV_BAD;
        end else begin
          st_dec = ST_VALUE;
        end
      end
      ST_ALMOST: begin
        if (s1_byte == CH_LF) ev = EV_LINE;
        else if (s1_byte != CH_CR) ev = EV_BAD;
      end
      default: begin
        if (s1_byte == CH_LF) ev = EV_HDR;
        else ev = EV_BAD;
      end
    endcase

    // A fresh name restarts hash and slot before the first char folds in.
    hash_base = new_name ? '0 : hash_acc;
    idx_base  = new_name ? '0 : char_index;
    if (store) begin
      hash_acc_next   = (hash_base << 5) - hash_base + {{(HASH_W-8){1'b0}}, sch};
      char_index_next = (idx_base == NAME_IDX_LAST) ? '0 : idx_base + 1'b1;
    end else begin
      hash_acc_next   = hash_base;
      char_index_next = idx_base;
    end

    if (ev != EV_CONT) begin
      line_offset_next = '0;
    end else if (p_inc[LINE_POS_W]) begin
      line_offset_next = LINE_POS_LAST;
    end else begin
      line_offset_next = p_inc[LINE_POS_W-1:0];
    end
  end

  // Next scan state: any reported event ends the line.
  always_comb begin
    if (ev != EV_CONT) scan_state_next = ST_START;
    else scan_state_next = st_dec;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      underscores_allowed <= 1'b0;
    end else if (wr_en) begin
      underscores_allowed <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_valid && !in_stall) begin
      s1_valid <= 1'b1;
    end else if (adv) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_byte <= data_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      scan_state      <= ST_START;
      hash_acc        <= '0;
      char_index      <= '0;
      bad_name_flag   <= 1'b0;
      line_offset     <= '0;
      name_end_reg    <= '0;
      value_start_reg <= '0;
      value_end_reg   <= '0;
    end else if (adv) begin
      scan_state      <= scan_state_next;
      hash_acc        <= hash_acc_next;
      char_index      <= char_index_next;
      bad_name_flag   <= bad_name_flag_next;
      line_offset     <= line_offset_next;
      name_end_reg    <= name_end_reg_next;
      value_start_reg <= value_start_reg_next;
      value_end_reg   <= value_end_reg_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      event_res       <= ev;
      name_char_valid <= store;
      name_char       <= store ? sch : 8'h00;
      name_index      <= store ? 5'(idx_base) : 5'd0;
      name_invalid    <= bad_name_flag_next;
      name_hash       <= hash_acc_next;
      name_end_pos    <= 12'(name_end_reg_next);
      value_start_pos <= 12'(value_start_reg_next);
      value_end_pos   <= 12'(value_end_reg_next);
    end
  end

endmodule
`default_nettype wire
